// ===== sv/ssel_pkg.sv =====
// shared constants, command codes and helper functions for the stubborn set selector
// no dependencies

package ssel_pkg;

   localparam int NUM_ACTIONS = 32;
   localparam int NUM_GUARDS  = 32;
   localparam int ACT_IDX_W   = $clog2(NUM_ACTIONS);
   localparam int GRD_IDX_W   = $clog2(NUM_GUARDS);
   localparam int ROW_W       = 5;
   localparam int CMD_W       = 2;
   localparam int COUNT_W     = $clog2(NUM_ACTIONS + 1);

   typedef logic [NUM_ACTIONS-1:0] act_mask_type;
   typedef logic [NUM_GUARDS-1:0]  grd_mask_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_GUARD = 2'd0,
      CMD_WR_NC    = 2'd1,
      CMD_WR_NES   = 2'd2,
      CMD_EVAL     = 2'd3
   } cmd_type;

   function automatic logic [ACT_IDX_W-1:0] lowest_action(input act_mask_type m);
      logic [ACT_IDX_W-1:0] r;
      r = '0;
      for (int i = NUM_ACTIONS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = ACT_IDX_W'(i);
         end
      end
      return r;
   endfunction

   function automatic logic [GRD_IDX_W-1:0] lowest_guard(input grd_mask_type m);
      logic [GRD_IDX_W-1:0] r;
      r = '0;
      for (int i = NUM_GUARDS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = GRD_IDX_W'(i);
         end
      end
      return r;
   endfunction

endpackage

// ===== sv/stubborn_set_selector.sv =====
// evaluate item: a scan step (one action guard row compared per cycle, in index order), a seed step,
// then a close step per popped enabled action and a close and a nes step per popped disabled action,
// then a result step; a table write item is written while idle and leaves the block ready
// the result sits in an output register, so the next item is taken while it waits
// synchronous active-high reset clears all three tables, the sequencer and the result valid
// depends on ssel_pkg

module stubborn_set_selector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ssel_pkg::CMD_W-1:0]       req_command,
   input  logic [ssel_pkg::ROW_W-1:0]       req_row_index,
   input  logic [31:0]                      req_bit_mask,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [ssel_pkg::NUM_ACTIONS-1:0] rsp_selected_mask,
   output logic [ssel_pkg::NUM_ACTIONS-1:0] rsp_enabled_mask,
   output logic [ssel_pkg::COUNT_W-1:0]     rsp_enabled_selected_count
);
   import ssel_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_SEED  = 6'b000100,
      ST_CLOSE = 6'b001000,
      ST_NES   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   grd_mask_type guard_rows_ff [NUM_ACTIONS];
   act_mask_type nc_rows_ff    [NUM_ACTIONS];
   act_mask_type nes_rows_ff   [NUM_GUARDS];

   grd_mask_type          truth_ff, truth_in;
   logic [ACT_IDX_W-1:0]  idx_ff, idx_in;
   act_mask_type          enabled_ff, enabled_in;
   act_mask_type          selected_ff, selected_in;
   act_mask_type          pending_ff, pending_in;
   logic                  seed_found_ff, seed_found_in;
   logic [ACT_IDX_W-1:0]  seed_ff, seed_in;
   logic [GRD_IDX_W-1:0]  guard_ff, guard_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   act_mask_type          rsp_sel_ff, rsp_sel_in;
   act_mask_type          rsp_en_ff, rsp_en_in;
   logic [COUNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   logic                  accept;
   cmd_type               cmd;
   logic                  scan_hit;
   logic [ACT_IDX_W-1:0]  pop_idx;
   act_mask_type          pop_left;
   act_mask_type          add_mask;
   grd_mask_type          miss_mask;
   logic                  out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // table writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ACTIONS; i++) begin
            guard_rows_ff[i] <= '0;
            nc_rows_ff[i]    <= '0;
         end
         for (int i = 0; i < NUM_GUARDS; i++) begin
            nes_rows_ff[i] <= '0;
         end
      end else if (accept) begin
         unique case (cmd)
            CMD_WR_GUARD: begin
               if (32'(req_row_index) < NUM_ACTIONS) begin
                  guard_rows_ff[ACT_IDX_W'(req_row_index)] <= req_bit_mask[NUM_GUARDS-1:0];
               end
            end
            CMD_WR_NC: begin
               if (32'(req_row_index) < NUM_ACTIONS) begin
                  nc_rows_ff[ACT_IDX_W'(req_row_index)] <= req_bit_mask[NUM_ACTIONS-1:0];
               end
            end
            CMD_WR_NES: begin
               if (32'(req_row_index) < NUM_GUARDS) begin
                  nes_rows_ff[GRD_IDX_W'(req_row_index)] <= req_bit_mask[NUM_ACTIONS-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign scan_hit  = (guard_rows_ff[idx_ff] & ~truth_ff) == '0;
   assign pop_idx   = lowest_action(pending_ff);
   assign miss_mask = guard_rows_ff[pop_idx] & ~truth_ff;

   always_comb begin
      state_in      = state_ff;
      truth_in      = truth_ff;
      idx_in        = idx_ff;
      enabled_in    = enabled_ff;
      selected_in   = selected_ff;
      pending_in    = pending_ff;
      seed_found_in = seed_found_ff;
      seed_in       = seed_ff;
      guard_in      = guard_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sel_in    = rsp_sel_ff;
      rsp_en_in     = rsp_en_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      pop_left      = pending_ff;
      pop_left[pop_idx] = 1'b0;
      add_mask      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && cmd == CMD_EVAL) begin
               truth_in      = req_bit_mask[NUM_GUARDS-1:0];
               idx_in        = '0;
               enabled_in    = '0;
               seed_found_in = 1'b0;
               count_in      = '0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            enabled_in[idx_ff] = scan_hit;
            if (scan_hit && !seed_found_ff) begin
               seed_in       = idx_ff;
               seed_found_in = 1'b1;
            end
            if (32'(idx_ff) == NUM_ACTIONS - 1) begin
               state_in = ST_SEED;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SEED: begin
            selected_in = '0;
            if (seed_found_ff) begin
               selected_in[seed_ff] = 1'b1;
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_DONE;
            end
            pending_in = selected_in;
         end
         ST_CLOSE: begin
            if (enabled_ff[pop_idx]) begin
               add_mask    = nc_rows_ff[pop_idx] & ~selected_ff;
               selected_in = selected_ff | add_mask;
               pending_in  = pop_left | add_mask;
               count_in    = count_ff + 1'b1;
               state_in    = (pending_in == '0) ? ST_DONE : ST_CLOSE;
            end else begin
               // disabled action always has a false guard
               pending_in = pop_left;
               guard_in   = lowest_guard(miss_mask);
               state_in   = ST_NES;
            end
         end
         ST_NES: begin
            add_mask    = nes_rows_ff[guard_ff] & ~selected_ff;
            selected_in = selected_ff | add_mask;
            pending_in  = pending_ff | add_mask;
            state_in    = (pending_in == '0) ? ST_DONE : ST_CLOSE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sel_in   = selected_ff;
               rsp_en_in    = enabled_ff;
               rsp_cnt_in   = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         seed_found_ff <= 1'b0;
         pending_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         seed_found_ff <= seed_found_in;
         pending_ff    <= pending_in;
      end
   end

   always_ff @(posedge clock) begin
      truth_ff    <= truth_in;
      idx_ff      <= idx_in;
      enabled_ff  <= enabled_in;
      selected_ff <= selected_in;
      seed_ff     <= seed_in;
      guard_ff    <= guard_in;
      count_ff    <= count_in;
      rsp_sel_ff  <= rsp_sel_in;
      rsp_en_ff   <= rsp_en_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_valid                  = rsp_valid_ff;
   assign rsp_selected_mask          = rsp_sel_ff;
   assign rsp_enabled_mask           = rsp_en_ff;
   assign rsp_enabled_selected_count = rsp_cnt_ff;

endmodule

// ===== sv/ssel_check.sv =====
// port-level checks for the stubborn set selector, bound to the top level
// depends on ssel_pkg and stubborn_set_selector

module ssel_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic [ssel_pkg::CMD_W-1:0]       req_command,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ssel_pkg::NUM_ACTIONS-1:0] rsp_selected_mask,
   input logic [ssel_pkg::NUM_ACTIONS-1:0] rsp_enabled_mask,
   input logic [ssel_pkg::COUNT_W-1:0]     rsp_enabled_selected_count
);
   import ssel_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_selected_mask)
         && $stable(rsp_enabled_mask) && $stable(rsp_enabled_selected_count))
      else $error("result changed while stalled");

   // an evaluate item occupies the block
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_EVAL |=> !req_ready)
      else $error("ready after evaluate item");

   // a table write leaves the block ready for the next item
   a_write_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command != CMD_EVAL |=> req_ready)
      else $error("write item stalled the block");

   // count is zero exactly when no selected action is enabled
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_enabled_selected_count == '0)
         == ((rsp_selected_mask & rsp_enabled_mask) == '0)))
      else $error("count disagrees with masks");

   // selection is empty exactly when no action is enabled
   a_seed_sel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_enabled_mask == '0) == (rsp_selected_mask == '0)))
      else $error("selection empty with enabled actions");

endmodule

bind stubborn_set_selector ssel_check u_ssel_check (.*);

// ===== verif/stubborn_set_selector_tb.sv =====
// self-checking testbench for stubborn_set_selector: table writes and evaluate items,
// an in-bench closure predictor and an in-order result scoreboard
// depends on ssel_pkg and stubborn_set_selector

module stubborn_set_selector_tb;
   import ssel_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 500;
   localparam int PHASE_ITEMS  = 240;
   localparam int NUM_PHASES   = 5;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      cmd_type              cmd;
      logic [ROW_W-1:0]     row;
      logic [31:0]          bits;
   } ssel_item_type;

   typedef struct packed {
      act_mask_type         selected;
      act_mask_type         enabled;
      logic [COUNT_W-1:0]   count;
   } ssel_outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_command = CMD_WR_GUARD;
   logic [ROW_W-1:0]       req_row_index = '0;
   logic [31:0]            req_bit_mask = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   act_mask_type           rsp_selected_mask;
   act_mask_type           rsp_enabled_mask;
   logic [COUNT_W-1:0]     rsp_enabled_selected_count;

   ssel_item_type          queued_commands[$];
   ssel_outcome_type       expected_selections[$];
   ssel_item_type          item_on_bus;
   bit                     req_taken = 1'b0;

   grd_mask_type           model_guard[32];
   act_mask_type           model_conflict[32];
   act_mask_type           model_nes[32];

   int                     send_idle_pct = 0;
   int                     recv_stall_pct = 0;
   int                     holds_asked = 0;
   int                     holds_served = 0;
   int                     stall_left = 0;
   int                     failures = 0;
   int                     cycle_count = 0;
   int                     items_queued = 0;

   stubborn_set_selector DUT (
      .clock                      (clock),
      .reset                      (reset),
      .req_valid                  (req_valid),
      .req_ready                  (req_ready),
      .req_command                (req_command),
      .req_row_index              (req_row_index),
      .req_bit_mask               (req_bit_mask),
      .rsp_valid                  (rsp_valid),
      .rsp_ready                  (rsp_ready),
      .rsp_selected_mask          (rsp_selected_mask),
      .rsp_enabled_mask           (rsp_enabled_mask),
      .rsp_enabled_selected_count (rsp_enabled_selected_count)
   );

   always #1 clock = ~clock;

   function automatic int lowest_set(input logic [31:0] m);
      for (int i = 0; i < 32; i++) begin
         if (m[i]) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic logic [31:0] scatter_bits(input int n);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < n; i++) begin
         m[$urandom_range(31)] = 1'b1;
      end
      return m;
   endfunction

   task automatic predict_selection(input ssel_item_type it);
      act_mask_type     enabled;
      act_mask_type     chosen;
      act_mask_type     frontier;
      act_mask_type     grow;
      grd_mask_type     truth;
      ssel_outcome_type outcome;
      int               a;
      int               g;
      case (it.cmd)
         CMD_WR_GUARD: begin
            if (it.row < NUM_ACTIONS) model_guard[it.row] = it.bits;
         end
         CMD_WR_NC: begin
            if (it.row < NUM_ACTIONS) model_conflict[it.row] = it.bits;
         end
         CMD_WR_NES: begin
            if (it.row < NUM_GUARDS) model_nes[it.row] = it.bits;
         end
         default: begin
            truth = it.bits;
            enabled = '0;
            for (a = 0; a < NUM_ACTIONS; a++) begin
               enabled[a] = ((model_guard[a] & ~truth) == '0);
            end
            chosen = '0;
            a = lowest_set(enabled);
            if (a >= 0) chosen[a] = 1'b1;
            frontier = chosen;
            while (frontier != '0) begin
               a = lowest_set(frontier);
               frontier[a] = 1'b0;
               if (enabled[a]) begin
                  grow = model_conflict[a];
               end else begin
                  g = lowest_set(model_guard[a] & ~truth);
                  grow = (g >= 0) ? model_nes[g] : '0;
               end
               grow = grow & ~chosen;
               chosen = chosen | grow;
               frontier = frontier | grow;
            end
            outcome.selected = chosen;
            outcome.enabled = enabled;
            outcome.count = COUNT_W'($countones(chosen & enabled));
            expected_selections.push_back(outcome);
         end
      endcase
   endtask

   task automatic push_item(input cmd_type c, input int row, input logic [31:0] bits);
      ssel_item_type it;
      it.cmd = c;
      it.row = ROW_W'(row);
      it.bits = bits;
      queued_commands.push_back(it);
      items_queued++;
   endtask

   // every action guarded, first evaluate finds nothing enabled
   task automatic queue_lockout();
      int n;
      for (int a = 0; a < NUM_ACTIONS; a++) begin
         push_item(CMD_WR_GUARD, a, scatter_bits(1 + $urandom_range(1)));
      end
      n = 1 + $urandom_range(2);
      for (int k = 0; k < n; k++) begin
         push_item(CMD_EVAL, $urandom_range(31),
                   (k == 0) ? 32'h0 : ~scatter_bits($urandom_range(6)));
      end
   endtask

   task automatic queue_random(input int n_items);
      int      target;
      int      pick;
      int      nw;
      int      ne;
      cmd_type c;
      target = items_queued + n_items;
      while (items_queued < target) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            nw = 1 + $urandom_range(2);
            for (int k = 0; k < nw; k++) begin
               push_item(cmd_type'($urandom_range(3)), $urandom_range(31), $urandom);
            end
         end else if (pick < 14) begin
            queue_lockout();
         end else begin
            nw = 1 + $urandom_range(5);
            for (int k = 0; k < nw; k++) begin
               c = cmd_type'($urandom_range(2));
               push_item(c, $urandom_range(31),
                         ($urandom_range(9) == 0) ? $urandom :
                         scatter_bits($urandom_range((c == CMD_WR_GUARD) ? 3 : 5)));
            end
            ne = 1 + $urandom_range(3);
            for (int k = 0; k < ne; k++) begin
               push_item(CMD_EVAL, $urandom_range(31),
                         ($urandom_range(9) == 0) ? $urandom : ~scatter_bits($urandom_range(4)));
            end
         end
      end
   endtask

   task automatic wait_all_results();
      while (queued_commands.size() != 0 || req_valid || expected_selections.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_command <= CMD_WR_GUARD;
         req_row_index <= '0;
         req_bit_mask <= '0;
      end else if (!req_valid || req_taken) begin
         if (queued_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            item_on_bus = queued_commands.pop_front();
            req_valid <= 1'b1;
            req_command <= item_on_bus.cmd;
            req_row_index <= item_on_bus.row;
            req_bit_mask <= item_on_bus.bits;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (holds_served != holds_asked) begin
         rsp_ready <= 1'b0;
         stall_left = HOLD_CYCLES - 1;
         holds_served++;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // input item accepted
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) predict_selection(item_on_bus);
      end
   end

   // monitor
   always @(posedge clock) begin
      ssel_outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_selections.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("unexpected result: selected %h enabled %h count %0d",
                        rsp_selected_mask, rsp_enabled_mask, rsp_enabled_selected_count);
            end
         end else begin
            want = expected_selections.pop_front();
            if (rsp_selected_mask !== want.selected || rsp_enabled_mask !== want.enabled ||
                rsp_enabled_selected_count !== want.count) begin
               failures++;
               if (failures <= MAX_REPORTS) begin
                  $display({"mismatch: selected exp %h got %h, enabled exp %h got %h, ",
                            "count exp %0d got %0d"},
                           want.selected, rsp_selected_mask, want.enabled, rsp_enabled_mask,
                           want.count, rsp_enabled_selected_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stubborn_set_selector regression: fail");
         $finish;
      end
   end

   initial begin
      int send_plan[NUM_PHASES];
      int recv_plan[NUM_PHASES];
      send_plan = '{0, 71, 0, 29, 0};
      recv_plan = '{0, 0, 71, 29, 0};
      for (int i = 0; i < 32; i++) begin
         model_guard[i] = '0;
         model_conflict[i] = '0;
         model_nes[i] = '0;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty tables, walks through enabled and disabled actions, extremes
      push_item(CMD_EVAL, 0, 32'hFFFF_FFFF);
      push_item(CMD_WR_NC, 0, 32'h8000_0004);
      push_item(CMD_WR_GUARD, 2, 32'h0000_0006);
      push_item(CMD_WR_NES, 1, 32'h0000_0021);
      push_item(CMD_WR_NES, 2, 32'h0000_0080);
      push_item(CMD_WR_NC, 5, 32'h0000_0200);
      push_item(CMD_EVAL, 7, ~32'h0000_0002);
      push_item(CMD_EVAL, 31, ~32'h0000_0006);
      push_item(CMD_EVAL, 0, ~32'h0000_0004);
      push_item(CMD_WR_GUARD, 0, 32'hFFFF_FFFF);
      push_item(CMD_WR_GUARD, 31, 32'h8000_0000);
      push_item(CMD_EVAL, 0, 32'h0000_0000);
      push_item(CMD_WR_NC, 1, 32'hFFFF_FFFF);
      push_item(CMD_EVAL, 31, 32'h0000_0000);
      push_item(CMD_WR_NES, 31, 32'hFFFF_FFFF);
      push_item(CMD_WR_NES, 0, 32'h0000_0000);
      push_item(CMD_EVAL, 0, 32'h7FFF_FFFF);
      push_item(CMD_EVAL, 0, 32'hFFFF_FFFF);
      push_item(CMD_WR_GUARD, 31, 32'h0000_0000);
      push_item(CMD_WR_NC, 31, 32'hAAAA_AAAA);
      push_item(CMD_WR_NC, 1, 32'h8000_0000);
      push_item(CMD_EVAL, 16, 32'h5555_5555);
      queue_lockout();
      wait_all_results();

      for (int p = 0; p < NUM_PHASES; p++) begin
         send_idle_pct = send_plan[p];
         recv_stall_pct = recv_plan[p];
         queue_random(PHASE_ITEMS);
         if (p == 2 || p == 4) holds_asked++;
         wait_all_results();
      end

      repeat (120) @(posedge clock);
      if (failures == 0 && expected_selections.size() == 0) begin
         $display("stubborn_set_selector regression: pass");
      end else begin
         $display("stubborn_set_selector regression: fail");
      end
      $finish;
   end

endmodule
